### hw/rtl/dpcr_pkg.sv
package dpcr_pkg;

    localparam int DEF_VALUE_WIDTH = 32;
    localparam int DEF_FRAC_BITS   = 16;

    // latencies of the arithmetic units, in register stages
    localparam int MUL_LAT  = 2;
    localparam int DIV_LAT  = 64;
    localparam int SQRT_LAT = 64;

    localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

    // multiplier slots
    localparam int MA_RX2  = 0;
    localparam int MA_RY2  = 1;
    localparam int MA_SS   = 2;
    localparam int MA_RXVX = 3;
    localparam int MA_RYVY = 4;
    localparam int MA_VXVX = 5;
    localparam int MA_VYVY = 6;
    localparam int MA_RXVY = 7;
    localparam int MA_RYVX = 8;
    localparam int MB_BIG  = 9;
    localparam int MB_CC   = 10;
    localparam int MC_1X   = 11;
    localparam int MC_1Y   = 12;
    localparam int MC_2X   = 13;
    localparam int MC_2Y   = 14;
    localparam int MD_QX2  = 15;
    localparam int MD_QY2  = 16;
    localparam int MD_VXQX = 17;
    localparam int MD_VYQY = 18;
    localparam int ME_X    = 19;
    localparam int ME_Y    = 20;
    localparam int MF_1X   = 21;
    localparam int MF_1Y   = 22;
    localparam int MF_2X   = 23;
    localparam int MF_2Y   = 24;
    localparam int MG_1X   = 25;
    localparam int MG_1Y   = 26;
    localparam int MG_2X   = 27;
    localparam int MG_2Y   = 28;
    localparam int NMUL    = 29;

    // divider slots
    localparam int DV_DT = 0;
    localparam int DV_WX = 1;
    localparam int DV_WY = 2;
    localparam int DV_F1 = 3;
    localparam int DV_F2 = 4;
    localparam int NDIV  = 5;

    // pipeline schedule, stage index at which each step reads its operands
    localparam int K_SUB   = 0;
    localparam int K_MA    = 1;
    localparam int K_MDIV  = 1;
    localparam int K_HIT   = K_MA + MUL_LAT;
    localparam int K_MB    = K_HIT + 1;
    localparam int K_DD    = K_MB + MUL_LAT;
    localparam int K_SQ    = K_DD + 1;
    localparam int K_NN    = K_SQ + SQRT_LAT;
    localparam int K_DTDIV = K_NN + 1;
    localparam int K_DT    = K_DTDIV + DIV_LAT;
    localparam int K_F     = K_MDIV + DIV_LAT;
    localparam int K_MC    = K_DT + 1;
    localparam int K_BP    = K_MC + MUL_LAT;
    localparam int K_Q     = K_BP + 1;
    localparam int K_MD    = K_Q + 1;
    localparam int K_RR    = K_MD + MUL_LAT;
    localparam int K_ME    = K_RR + 1;
    localparam int K_WDIV  = K_ME + MUL_LAT;
    localparam int K_W     = K_WDIV + DIV_LAT;
    localparam int K_MF    = K_W + 1;
    localparam int K_V     = K_MF + MUL_LAT;
    localparam int K_MG    = K_V + 1;
    localparam int K_P     = K_MG + MUL_LAT;
    localparam int NST     = K_P + 1;

    typedef struct packed {
        logic signed [63:0] p1x, p1y, v1x, v1y, p2x, p2y, v2x, v2y;
        logic [63:0]        r1, r2, m1, m2, msum, s;
        logic               msz;
        logic signed [63:0] rx, ry, vx, vy;
        logic               hit;
        logic signed [63:0] dot, vv, cr;
        logic [63:0]        ssq;
        logic [127:0]       dd;
        logic signed [63:0] nn, dt;
        logic signed [63:0] bp1x, bp1y, bp2x, bp2y, qx, qy, rr, dp;
        logic signed [63:0] f1, f2, wx, wy;
        logic signed [63:0] n1x, n1y, n2x, n2y, o1x, o1y, o2x, o2y;
    } ctx_t;

    function automatic logic [63:0] smag(input logic signed [63:0] a);
        return a[63] ? 64'(-a) : 64'(a);
    endfunction

    function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
        logic signed [64:0] t;
        t = {a[63], a} + {b[63], b};
        if (t[64] != t[63])
            return t[64] ? S64_MIN : S64_MAX;
        return t[63:0];
    endfunction

    function automatic logic signed [63:0] ssub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
        logic signed [64:0] t;
        t = {a[63], a} - {b[63], b};
        if (t[64] != t[63])
            return t[64] ? S64_MIN : S64_MAX;
        return t[63:0];
    endfunction

    // signed result from an unsigned magnitude and a sign
    function automatic logic signed [63:0] sfin(input logic [63:0] m, input logic neg);
        if (!neg)
            return m[63] ? S64_MAX : $signed(m);
        if (m[63])
            return S64_MIN;
        return $signed(-m);
    endfunction

    // product scaled down by the fraction bits, saturated
    function automatic logic [63:0] umq(input logic [127:0] p, input int q);
        logic [127:0] sh;
        sh = p >> q;
        return (sh[127:64] != 64'd0) ? {64{1'b1}} : sh[63:0];
    endfunction

    function automatic logic signed [63:0] mq(input logic [127:0] p, input logic neg,
                                              input int q);
        return sfin(umq(p, q), neg);
    endfunction

    function automatic logic signed [63:0] sext_w(input logic [63:0] x, input int w);
        logic signed [63:0] t;
        t = $signed(x << (64 - w));
        return t >>> (64 - w);
    endfunction

    function automatic logic signed [63:0] clamp_w(input logic signed [63:0] v,
                                                   input int w);
        logic signed [63:0] hi, lo;
        hi = (64'sd1 <<< (w - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

endpackage

### hw/rtl/disc_pair_collision_resolve_unit.sv
// channel   dir  payload
// s_axis    in   tdata: first pos_x, pos_y, vel_x, vel_y, radius, mass, then second (same)
// m_axis    out  tdata: new first pos_x, pos_y, vel_x, vel_y, then second; tuser: collided
//
// one pair enters per cycle while the output buffer is not full; results leave in order.
// the pipeline depth is mostly set by the chain of two 64-stage dividers and the 64-stage
// square root. reset clears valid bits and the output buffer's pointers and count only.
// a two-entry output buffer holds results; the whole pipeline stalls only
// when that buffer is full, and then nothing moves or is dropped.
module disc_pair_collision_resolve_unit #(
    parameter int VALUE_WIDTH = dpcr_pkg::DEF_VALUE_WIDTH,
    parameter int FRAC_BITS   = dpcr_pkg::DEF_FRAC_BITS,
    localparam int IN_W  = ((12 * VALUE_WIDTH - 2 + 7) / 8) * 8,
    localparam int OUT_W = 8 * VALUE_WIDTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // first_pos_x, first_pos_y, first_vel_x, first_vel_y, first_radius, first_mass,
    // second_pos_x, second_pos_y, second_vel_x, second_vel_y, second_radius, second_mass
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // new_first_pos_x, new_first_pos_y, new_first_vel_x, new_first_vel_y,
    // new_second_pos_x, new_second_pos_y, new_second_vel_x, new_second_vel_y
    output logic [OUT_W-1:0] m_axis_tdata,
    // collided
    output logic             m_axis_tuser
);
    import dpcr_pkg::*;

    localparam int W = VALUE_WIDTH;
    localparam int Q = FRAC_BITS;
    localparam int O_P1X = 0;
    localparam int O_P1Y = W;
    localparam int O_V1X = 2 * W;
    localparam int O_V1Y = 3 * W;
    localparam int O_R1  = 4 * W;
    localparam int O_M1  = 5 * W - 1;
    localparam int O_P2X = 6 * W - 1;
    localparam int O_P2Y = 7 * W - 1;
    localparam int O_V2X = 8 * W - 1;
    localparam int O_V2Y = 9 * W - 1;
    localparam int O_R2  = 10 * W - 1;
    localparam int O_M2  = 11 * W - 2;
    localparam int BUF_W = OUT_W + 1;

    logic        adv;
    ctx_t        in_ctx;
    ctx_t        st_reg  [NST+1];
    ctx_t        st_next [NST];
    logic        vld_reg [NST+1];

    logic [63:0]  mul_a [NMUL];
    logic [63:0]  mul_b [NMUL];
    logic [127:0] mul_p [NMUL];
    logic [63:0]  div_hi [NDIV];
    logic [63:0]  div_lo [NDIV];
    logic [63:0]  div_den [NDIV];
    logic [63:0]  div_q [NDIV];
    logic [63:0]  sq_root;

    logic [BUF_W-1:0] buf_reg [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       cnt_reg;
    logic [BUF_W-1:0] out_word;
    logic             push, pop;

    assign adv           = (cnt_reg != 2'd2);
    assign s_axis_tready = adv;

    always_comb
    begin
        in_ctx     = '0;
        in_ctx.p1x = sext_w(64'(s_axis_tdata[O_P1X +: W]), W);
        in_ctx.p1y = sext_w(64'(s_axis_tdata[O_P1Y +: W]), W);
        in_ctx.v1x = sext_w(64'(s_axis_tdata[O_V1X +: W]), W);
        in_ctx.v1y = sext_w(64'(s_axis_tdata[O_V1Y +: W]), W);
        in_ctx.r1  = 64'(s_axis_tdata[O_R1 +: W-1]);
        in_ctx.m1  = 64'(s_axis_tdata[O_M1 +: W]);
        in_ctx.p2x = sext_w(64'(s_axis_tdata[O_P2X +: W]), W);
        in_ctx.p2y = sext_w(64'(s_axis_tdata[O_P2Y +: W]), W);
        in_ctx.v2x = sext_w(64'(s_axis_tdata[O_V2X +: W]), W);
        in_ctx.v2y = sext_w(64'(s_axis_tdata[O_V2Y +: W]), W);
        in_ctx.r2  = 64'(s_axis_tdata[O_R2 +: W-1]);
        in_ctx.m2  = 64'(s_axis_tdata[O_M2 +: W]);
    end

    // arithmetic units, one per slot
    always_comb
    begin
        mul_a[MA_RX2]  = smag(st_reg[K_MA].rx);  mul_b[MA_RX2]  = smag(st_reg[K_MA].rx);
        mul_a[MA_RY2]  = smag(st_reg[K_MA].ry);  mul_b[MA_RY2]  = smag(st_reg[K_MA].ry);
        mul_a[MA_SS]   = st_reg[K_MA].s;         mul_b[MA_SS]   = st_reg[K_MA].s;
        mul_a[MA_RXVX] = smag(st_reg[K_MA].rx);  mul_b[MA_RXVX] = smag(st_reg[K_MA].vx);
        mul_a[MA_RYVY] = smag(st_reg[K_MA].ry);  mul_b[MA_RYVY] = smag(st_reg[K_MA].vy);
        mul_a[MA_VXVX] = smag(st_reg[K_MA].vx);  mul_b[MA_VXVX] = smag(st_reg[K_MA].vx);
        mul_a[MA_VYVY] = smag(st_reg[K_MA].vy);  mul_b[MA_VYVY] = smag(st_reg[K_MA].vy);
        mul_a[MA_RXVY] = smag(st_reg[K_MA].rx);  mul_b[MA_RXVY] = smag(st_reg[K_MA].vy);
        mul_a[MA_RYVX] = smag(st_reg[K_MA].ry);  mul_b[MA_RYVX] = smag(st_reg[K_MA].vx);
        mul_a[MB_BIG]  = st_reg[K_MB].ssq;       mul_b[MB_BIG]  = smag(st_reg[K_MB].vv);
        mul_a[MB_CC]   = smag(st_reg[K_MB].cr);  mul_b[MB_CC]   = smag(st_reg[K_MB].cr);
        mul_a[MC_1X]   = smag(st_reg[K_MC].dt);  mul_b[MC_1X]   = smag(st_reg[K_MC].v1x);
        mul_a[MC_1Y]   = smag(st_reg[K_MC].dt);  mul_b[MC_1Y]   = smag(st_reg[K_MC].v1y);
        mul_a[MC_2X]   = smag(st_reg[K_MC].dt);  mul_b[MC_2X]   = smag(st_reg[K_MC].v2x);
        mul_a[MC_2Y]   = smag(st_reg[K_MC].dt);  mul_b[MC_2Y]   = smag(st_reg[K_MC].v2y);
        mul_a[MD_QX2]  = smag(st_reg[K_MD].qx);  mul_b[MD_QX2]  = smag(st_reg[K_MD].qx);
        mul_a[MD_QY2]  = smag(st_reg[K_MD].qy);  mul_b[MD_QY2]  = smag(st_reg[K_MD].qy);
        mul_a[MD_VXQX] = smag(st_reg[K_MD].vx);  mul_b[MD_VXQX] = smag(st_reg[K_MD].qx);
        mul_a[MD_VYQY] = smag(st_reg[K_MD].vy);  mul_b[MD_VYQY] = smag(st_reg[K_MD].qy);
        mul_a[ME_X]    = smag(st_reg[K_ME].dp);  mul_b[ME_X]    = smag(st_reg[K_ME].qx);
        mul_a[ME_Y]    = smag(st_reg[K_ME].dp);  mul_b[ME_Y]    = smag(st_reg[K_ME].qy);
        mul_a[MF_1X]   = smag(st_reg[K_MF].f1);  mul_b[MF_1X]   = smag(st_reg[K_MF].wx);
        mul_a[MF_1Y]   = smag(st_reg[K_MF].f1);  mul_b[MF_1Y]   = smag(st_reg[K_MF].wy);
        mul_a[MF_2X]   = smag(st_reg[K_MF].f2);  mul_b[MF_2X]   = smag(st_reg[K_MF].wx);
        mul_a[MF_2Y]   = smag(st_reg[K_MF].f2);  mul_b[MF_2Y]   = smag(st_reg[K_MF].wy);
        mul_a[MG_1X]   = smag(st_reg[K_MG].dt);  mul_b[MG_1X]   = smag(st_reg[K_MG].n1x);
        mul_a[MG_1Y]   = smag(st_reg[K_MG].dt);  mul_b[MG_1Y]   = smag(st_reg[K_MG].n1y);
        mul_a[MG_2X]   = smag(st_reg[K_MG].dt);  mul_b[MG_2X]   = smag(st_reg[K_MG].n2x);
        mul_a[MG_2Y]   = smag(st_reg[K_MG].dt);  mul_b[MG_2Y]   = smag(st_reg[K_MG].n2y);
    end

    always_comb
    begin
        logic [127:0] tn, t1, t2;
        tn = 128'(smag(st_reg[K_DTDIV].nn)) << Q;
        t1 = 128'(st_reg[K_MDIV].m2) << (Q + 1);
        t2 = 128'(st_reg[K_MDIV].m1) << (Q + 1);
        div_hi[DV_DT]  = tn[127:64];
        div_lo[DV_DT]  = tn[63:0];
        div_den[DV_DT] = 64'(st_reg[K_DTDIV].vv);
        div_hi[DV_WX]  = mul_p[ME_X][127:64];
        div_lo[DV_WX]  = mul_p[ME_X][63:0];
        div_den[DV_WX] = 64'(st_reg[K_WDIV].rr);
        div_hi[DV_WY]  = mul_p[ME_Y][127:64];
        div_lo[DV_WY]  = mul_p[ME_Y][63:0];
        div_den[DV_WY] = 64'(st_reg[K_WDIV].rr);
        div_hi[DV_F1]  = t1[127:64];
        div_lo[DV_F1]  = t1[63:0];
        div_den[DV_F1] = st_reg[K_MDIV].msum;
        div_hi[DV_F2]  = t2[127:64];
        div_lo[DV_F2]  = t2[63:0];
        div_den[DV_F2] = st_reg[K_MDIV].msum;
    end

    for (genvar i = 0; i < NMUL; i++)
    begin : g_mul
        dpcr_umul u_mul (
            .clk (clk),
            .en  (adv),
            .a   (mul_a[i]),
            .b   (mul_b[i]),
            .p   (mul_p[i])
        );
    end

    for (genvar i = 0; i < NDIV; i++)
    begin : g_div
        dpcr_udiv u_div (
            .clk    (clk),
            .en     (adv),
            .num_hi (div_hi[i]),
            .num_lo (div_lo[i]),
            .den    (div_den[i]),
            .quo    (div_q[i])
        );
    end

    dpcr_sqrt u_sqrt (
        .clk  (clk),
        .en   (adv),
        .rad  (st_reg[K_SQ].dd),
        .root (sq_root)
    );

    // stage transitions
    always_comb
    begin
        logic [64:0]  msum_w;
        logic [63:0]  m1h, m2h;
        logic [128:0] d2;
        logic [127:0] bigz;
        logic         upd;
        for (int k = 0; k < NST; k++)
            st_next[k] = st_reg[k];

        st_next[K_SUB].rx = ssub(st_reg[K_SUB].p2x, st_reg[K_SUB].p1x);
        st_next[K_SUB].ry = ssub(st_reg[K_SUB].p2y, st_reg[K_SUB].p1y);
        st_next[K_SUB].vx = ssub(st_reg[K_SUB].v2x, st_reg[K_SUB].v1x);
        st_next[K_SUB].vy = ssub(st_reg[K_SUB].v2y, st_reg[K_SUB].v1y);
        st_next[K_SUB].s  = st_reg[K_SUB].r1 + st_reg[K_SUB].r2;
        // halve both masses when their sum overflows
        msum_w = 65'(st_reg[K_SUB].m1) + 65'(st_reg[K_SUB].m2);
        m1h    = msum_w[64] ? (st_reg[K_SUB].m1 >> 1) : st_reg[K_SUB].m1;
        m2h    = msum_w[64] ? (st_reg[K_SUB].m2 >> 1) : st_reg[K_SUB].m2;
        st_next[K_SUB].m1   = m1h;
        st_next[K_SUB].m2   = m2h;
        st_next[K_SUB].msum = m1h + m2h;
        st_next[K_SUB].msz  = ((m1h + m2h) == 64'd0);

        d2 = 129'(mul_p[MA_RX2]) + 129'(mul_p[MA_RY2]);
        st_next[K_HIT].hit = ((st_reg[K_HIT].rx != 64'sd0) || (st_reg[K_HIT].ry != 64'sd0))
                           && !d2[128] && (d2[127:0] <= mul_p[MA_SS]);
        st_next[K_HIT].dot = sadd(
            mq(mul_p[MA_RXVX], st_reg[K_HIT].rx[63] ^ st_reg[K_HIT].vx[63], Q),
            mq(mul_p[MA_RYVY], st_reg[K_HIT].ry[63] ^ st_reg[K_HIT].vy[63], Q));
        st_next[K_HIT].vv = sadd(mq(mul_p[MA_VXVX], 1'b0, Q), mq(mul_p[MA_VYVY], 1'b0, Q));
        st_next[K_HIT].cr = ssub(
            mq(mul_p[MA_RXVY], st_reg[K_HIT].rx[63] ^ st_reg[K_HIT].vy[63], Q),
            mq(mul_p[MA_RYVX], st_reg[K_HIT].ry[63] ^ st_reg[K_HIT].vx[63], Q));
        st_next[K_HIT].ssq = umq(mul_p[MA_SS], Q);

        // discriminant clamped at zero
        bigz = st_reg[K_DD].vv[63] ? 128'd0 : mul_p[MB_BIG];
        st_next[K_DD].dd = (bigz <= mul_p[MB_CC]) ? 128'd0 : (bigz - mul_p[MB_CC]);

        st_next[K_NN].nn = ssub(ssub(64'sd0, st_reg[K_NN].dot), $signed(sq_root));

        st_next[K_DT].dt = (st_reg[K_DT].vv > 64'sd0)
                         ? sfin(div_q[DV_DT], st_reg[K_DT].nn[63]) : 64'sd0;

        st_next[K_F].f1 = st_reg[K_F].msz ? $signed(64'd1 << Q) : $signed(div_q[DV_F1]);
        st_next[K_F].f2 = st_reg[K_F].msz ? $signed(64'd1 << Q) : $signed(div_q[DV_F2]);

        st_next[K_BP].bp1x = sadd(st_reg[K_BP].p1x,
            mq(mul_p[MC_1X], st_reg[K_BP].dt[63] ^ st_reg[K_BP].v1x[63], Q));
        st_next[K_BP].bp1y = sadd(st_reg[K_BP].p1y,
            mq(mul_p[MC_1Y], st_reg[K_BP].dt[63] ^ st_reg[K_BP].v1y[63], Q));
        st_next[K_BP].bp2x = sadd(st_reg[K_BP].p2x,
            mq(mul_p[MC_2X], st_reg[K_BP].dt[63] ^ st_reg[K_BP].v2x[63], Q));
        st_next[K_BP].bp2y = sadd(st_reg[K_BP].p2y,
            mq(mul_p[MC_2Y], st_reg[K_BP].dt[63] ^ st_reg[K_BP].v2y[63], Q));

        st_next[K_Q].qx = ssub(st_reg[K_Q].bp2x, st_reg[K_Q].bp1x);
        st_next[K_Q].qy = ssub(st_reg[K_Q].bp2y, st_reg[K_Q].bp1y);

        st_next[K_RR].rr = sadd(mq(mul_p[MD_QX2], 1'b0, Q), mq(mul_p[MD_QY2], 1'b0, Q));
        st_next[K_RR].dp = sadd(
            mq(mul_p[MD_VXQX], st_reg[K_RR].vx[63] ^ st_reg[K_RR].qx[63], Q),
            mq(mul_p[MD_VYQY], st_reg[K_RR].vy[63] ^ st_reg[K_RR].qy[63], Q));

        st_next[K_W].wx = sfin(div_q[DV_WX], st_reg[K_W].dp[63] ^ st_reg[K_W].qx[63]);
        st_next[K_W].wy = sfin(div_q[DV_WY], st_reg[K_W].dp[63] ^ st_reg[K_W].qy[63]);

        // impulse only when the discs collide and the normal does not vanish
        upd = st_reg[K_V].hit && (st_reg[K_V].rr > 64'sd0);
        if (upd)
        begin
            st_next[K_V].n1x = clamp_w(sadd(st_reg[K_V].v1x,
                mq(mul_p[MF_1X], st_reg[K_V].f1[63] ^ st_reg[K_V].wx[63], Q)), W);
            st_next[K_V].n1y = clamp_w(sadd(st_reg[K_V].v1y,
                mq(mul_p[MF_1Y], st_reg[K_V].f1[63] ^ st_reg[K_V].wy[63], Q)), W);
            st_next[K_V].n2x = clamp_w(ssub(st_reg[K_V].v2x,
                mq(mul_p[MF_2X], st_reg[K_V].f2[63] ^ st_reg[K_V].wx[63], Q)), W);
            st_next[K_V].n2y = clamp_w(ssub(st_reg[K_V].v2y,
                mq(mul_p[MF_2Y], st_reg[K_V].f2[63] ^ st_reg[K_V].wy[63], Q)), W);
        end
        else
        begin
            st_next[K_V].n1x = st_reg[K_V].v1x;
            st_next[K_V].n1y = st_reg[K_V].v1y;
            st_next[K_V].n2x = st_reg[K_V].v2x;
            st_next[K_V].n2y = st_reg[K_V].v2y;
        end

        if (st_reg[K_P].hit)
        begin
            st_next[K_P].o1x = ssub(st_reg[K_P].bp1x,
                mq(mul_p[MG_1X], st_reg[K_P].dt[63] ^ st_reg[K_P].n1x[63], Q));
            st_next[K_P].o1y = ssub(st_reg[K_P].bp1y,
                mq(mul_p[MG_1Y], st_reg[K_P].dt[63] ^ st_reg[K_P].n1y[63], Q));
            st_next[K_P].o2x = ssub(st_reg[K_P].bp2x,
                mq(mul_p[MG_2X], st_reg[K_P].dt[63] ^ st_reg[K_P].n2x[63], Q));
            st_next[K_P].o2y = ssub(st_reg[K_P].bp2y,
                mq(mul_p[MG_2Y], st_reg[K_P].dt[63] ^ st_reg[K_P].n2y[63], Q));
        end
        else
        begin
            st_next[K_P].o1x = st_reg[K_P].p1x;
            st_next[K_P].o1y = st_reg[K_P].p1y;
            st_next[K_P].o2x = st_reg[K_P].p2x;
            st_next[K_P].o2y = st_reg[K_P].p2y;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg[0] <= in_ctx;
            for (int k = 0; k < NST; k++)
                st_reg[k+1] <= st_next[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= NST; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= s_axis_tvalid;
            for (int k = 0; k < NST; k++)
                vld_reg[k+1] <= vld_reg[k];
        end
    end

    // output buffer
    assign out_word = {st_reg[NST].hit,
                       W'(clamp_w(st_reg[NST].n2y, W)), W'(clamp_w(st_reg[NST].n2x, W)),
                       W'(clamp_w(st_reg[NST].o2y, W)), W'(clamp_w(st_reg[NST].o2x, W)),
                       W'(clamp_w(st_reg[NST].n1y, W)), W'(clamp_w(st_reg[NST].n1x, W)),
                       W'(clamp_w(st_reg[NST].o1y, W)), W'(clamp_w(st_reg[NST].o1x, W))};
    assign push = adv && vld_reg[NST];
    assign pop  = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk)
    begin
        if (push)
            buf_reg[wr_ptr_reg] <= out_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign m_axis_tdata  = buf_reg[rd_ptr_reg][OUT_W-1:0];
    assign m_axis_tuser  = buf_reg[rd_ptr_reg][OUT_W];

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("output buffer count out of range");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (cnt_reg != 2'd0))
        else $error("pushed result not held in output buffer");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> (vld_reg[NST] == $past(vld_reg[NST])))
        else $error("pipeline moved while stalled");

    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2) |-> !push)
        else $error("push into full output buffer");
endmodule

### hw/rtl/dpcr_umul.sv
module dpcr_umul (
    input  logic         clk,
    input  logic         en,
    input  logic [63:0]  a,
    input  logic [63:0]  b,
    output logic [127:0] p
);
    logic [63:0]  pp00_reg, pp01_reg, pp10_reg, pp11_reg;
    logic [127:0] p_reg;
    logic [127:0] p_next;

    assign p_next = 128'(pp00_reg) + (128'(pp01_reg) << 32) + (128'(pp10_reg) << 32)
                  + (128'(pp11_reg) << 64);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp00_reg <= 64'(a[31:0])  * 64'(b[31:0]);
            pp01_reg <= 64'(a[31:0])  * 64'(b[63:32]);
            pp10_reg <= 64'(a[63:32]) * 64'(b[31:0]);
            pp11_reg <= 64'(a[63:32]) * 64'(b[63:32]);
            p_reg    <= p_next;
        end
    end

    assign p = p_reg;
endmodule

### hw/rtl/dpcr_udiv.sv
module dpcr_udiv (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] num_hi,
    input  logic [63:0] num_lo,
    input  logic [63:0] den,
    output logic [63:0] quo
);
    import dpcr_pkg::*;

    logic [63:0] rem_reg [DIV_LAT];
    logic [63:0] lo_reg  [DIV_LAT];
    logic [63:0] quo_reg [DIV_LAT];
    logic [63:0] den_reg [DIV_LAT];
    logic        sat_reg [DIV_LAT];
    logic [63:0] rem_next [DIV_LAT];
    logic [63:0] lo_next  [DIV_LAT];
    logic [63:0] quo_next [DIV_LAT];
    logic [63:0] den_next [DIV_LAT];
    logic        sat_next [DIV_LAT];

    // one quotient bit per stage
    always_comb
    begin
        logic [63:0] rs, ls, qs, ds;
        logic        ss;
        logic [64:0] r2;
        for (int i = 0; i < DIV_LAT; i++)
        begin
            if (i == 0)
            begin
                rs = num_hi;
                ls = num_lo;
                qs = 64'd0;
                ds = den;
                ss = (den == 64'd0) || (num_hi >= den);
            end
            else
            begin
                rs = rem_reg[i-1];
                ls = lo_reg[i-1];
                qs = quo_reg[i-1];
                ds = den_reg[i-1];
                ss = sat_reg[i-1];
            end
            r2 = {rs, ls[63]};
            if (r2 >= {1'b0, ds})
            begin
                rem_next[i] = 64'(r2 - {1'b0, ds});
                quo_next[i] = {qs[62:0], 1'b1};
            end
            else
            begin
                rem_next[i] = r2[63:0];
                quo_next[i] = {qs[62:0], 1'b0};
            end
            lo_next[i]  = {ls[62:0], 1'b0};
            den_next[i] = ds;
            sat_next[i] = ss;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < DIV_LAT; i++)
            begin
                rem_reg[i] <= rem_next[i];
                lo_reg[i]  <= lo_next[i];
                quo_reg[i] <= quo_next[i];
                den_reg[i] <= den_next[i];
                sat_reg[i] <= sat_next[i];
            end
        end
    end

    assign quo = sat_reg[DIV_LAT-1] ? {64{1'b1}} : quo_reg[DIV_LAT-1];
endmodule

### hw/rtl/dpcr_sqrt.sv
module dpcr_sqrt (
    input  logic         clk,
    input  logic         en,
    input  logic [127:0] rad,
    output logic [63:0]  root
);
    import dpcr_pkg::*;

    logic [66:0]  rem_reg  [SQRT_LAT];
    logic [127:0] rad_reg  [SQRT_LAT];
    logic [63:0]  root_reg [SQRT_LAT];
    logic [66:0]  rem_next  [SQRT_LAT];
    logic [127:0] rad_next  [SQRT_LAT];
    logic [63:0]  root_next [SQRT_LAT];

    // digit-by-digit square root, two radicand bits per stage
    always_comb
    begin
        logic [66:0]  rs, r2, trial;
        logic [127:0] ds;
        logic [63:0]  qs;
        for (int i = 0; i < SQRT_LAT; i++)
        begin
            if (i == 0)
            begin
                rs = 67'd0;
                ds = rad;
                qs = 64'd0;
            end
            else
            begin
                rs = rem_reg[i-1];
                ds = rad_reg[i-1];
                qs = root_reg[i-1];
            end
            r2    = {rs[64:0], ds[127:126]};
            trial = {1'b0, qs, 2'b01};
            if (r2 >= trial)
            begin
                rem_next[i]  = r2 - trial;
                root_next[i] = {qs[62:0], 1'b1};
            end
            else
            begin
                rem_next[i]  = r2;
                root_next[i] = {qs[62:0], 1'b0};
            end
            rad_next[i] = {ds[125:0], 2'b00};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < SQRT_LAT; i++)
            begin
                rem_reg[i]  <= rem_next[i];
                rad_reg[i]  <= rad_next[i];
                root_reg[i] <= root_next[i];
            end
        end
    end

    assign root = root_reg[SQRT_LAT-1];
endmodule
